>>> hw/rtl/prl_pkg.sv
// shared types and constants for the positional record list
`timescale 1ns / 1ps
`default_nettype none
package prl_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_MODIFY = 3'd2;
    localparam logic [2:0] KIND_GET    = 3'd3;
    localparam logic [2:0] KIND_FIND   = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BAD_POS  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NO_KEY   = 2'd3;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [31:0] key2;
        logic [63:0] name0;
        logic [63:0] name1;
        logic [63:0] name2;
        logic [47:0] name3;
        logic signed [31:0] cost;
    } t_record;

    // per-cell command from the list controller
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } t_cell_cmd;
endpackage
`default_nettype wire

>>> hw/rtl/prl_if.sv
// valid/ready channel interfaces for the record list
`timescale 1ns / 1ps
`default_nettype none
interface prl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [6:0]  position;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [31:0] key_word2;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [47:0] name_word3;
    logic signed [31:0] cost;
    modport source (output valid, kind, position, key_word0, key_word1, key_word2,
                    name_word0, name_word1, name_word2, name_word3, cost, input ready);
    modport sink   (input valid, kind, position, key_word0, key_word1, key_word2,
                    name_word0, name_word1, name_word2, name_word3, cost, output ready);
endinterface

interface prl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  entries;
    logic [63:0] out_key0;
    logic [63:0] out_key1;
    logic [31:0] out_key2;
    logic [63:0] out_name0;
    logic [63:0] out_name1;
    logic [63:0] out_name2;
    logic [47:0] out_name3;
    logic signed [31:0] out_cost;
    modport source (output valid, status, entries, out_key0, out_key1, out_key2,
                    out_name0, out_name1, out_name2, out_name3, out_cost, input ready);
    modport sink   (input valid, status, entries, out_key0, out_key1, out_key2,
                    out_name0, out_name1, out_name2, out_name3, out_cost, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/prl_cell.sv
// one list slot: holds a record, shifts with its neighbors, compares keys
`timescale 1ns / 1ps
`default_nettype none
module prl_cell
    import prl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire t_record   i_new,
    input  wire t_record   i_lower,
    input  wire t_record   i_upper,
    output t_record        o_rec,
    output logic           o_key_hit
);
    t_record r_rec;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rec <= i_new;
        end else if (i_cmd.shift_up) begin
            r_rec <= i_lower;
        end else if (i_cmd.shift_down) begin
            r_rec <= i_upper;
        end
    end

    assign o_rec     = r_rec;
    assign o_key_hit = (r_rec.key0 == i_new.key0) && (r_rec.key1 == i_new.key1)
                       && (r_rec.key2 == i_new.key2);
endmodule
`default_nettype wire

>>> hw/rtl/positional_record_list.sv
// top level of the positional record list
//
// ordered list of up to 64 records held in a chain of cells, one per slot
// requests arrive on i_req (valid/ready); each transaction is one operation:
// insert, delete, modify, get or find by key
// insert and delete shift every later cell by one place at once;
// find compares the key in all cells at once
// one response leaves on o_rsp for every request, in the cycle after it is
// taken, from an output register
// throughput: one operation per cycle unless stalled, set by the shift of the
// cell chain; the response register is reloaded when it is empty or taken
// when the receiver stalls, the response holds and new requests wait
// reset clears the entry count and the response valid; record contents
// are not cleared and are only ever read below the entry count
`timescale 1ns / 1ps
`default_nettype none
module positional_record_list
    import prl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prl_req_if.sink   i_req,
    prl_rsp_if.source o_rsp
);
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid;
    logic [1:0]       r_status, n_status;
    t_record          r_out, n_out;

    t_record   w_new;
    t_record   w_rec [CAPACITY];
    logic      w_hit [CAPACITY];
    t_cell_cmd w_cmd [CAPACITY];
    logic      w_take, w_ok_pos, w_ok_ins, w_any_hit;
    logic [IDX_W-1:0] w_idx;

    assign w_new = '{key0: i_req.key_word0, key1: i_req.key_word1, key2: i_req.key_word2,
                     name0: i_req.name_word0, name1: i_req.name_word1,
                     name2: i_req.name_word2, name3: i_req.name_word3, cost: i_req.cost};

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_take      = i_req.valid && i_req.ready;
    assign w_idx       = IDX_W'(i_req.position - 7'd1);
    assign w_ok_pos    = (i_req.position != 7'd0) && (i_req.position <= r_count);
    assign w_ok_ins    = (i_req.position != 7'd0) && (i_req.position <= r_count + 7'd1);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic w_ge;
            assign w_ge = (g >= int'(w_idx)) && w_take;
            assign w_cmd[g].load = w_take && w_idx == IDX_W'(g) &&
                ((i_req.kind == KIND_INSERT && w_ok_ins && r_count < CNT_W'(CAPACITY)) ||
                 (i_req.kind == KIND_MODIFY && w_ok_pos));
            assign w_cmd[g].shift_up = w_ge && g > int'(w_idx) &&
                i_req.kind == KIND_INSERT && w_ok_ins && r_count < CNT_W'(CAPACITY);
            assign w_cmd[g].shift_down = w_ge && i_req.kind == KIND_DELETE && w_ok_pos;
            prl_cell u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd[g]),
                .i_new    (w_new),
                .i_lower  (w_rec[(g == 0) ? 0 : g-1]),
                .i_upper  (w_rec[(g == CAPACITY-1) ? g : g+1]),
                .o_rec    (w_rec[g]),
                .o_key_hit(w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        w_any_hit = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_hit[k] && k < int'(r_count)) w_any_hit = 1'b1;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_BAD_POS;
        n_out    = '0;
        case (i_req.kind)
            KIND_INSERT: begin
                if (!w_ok_ins) n_status = ST_BAD_POS;
                else if (r_count >= CNT_W'(CAPACITY)) n_status = ST_FULL;
                else begin
                    n_status = ST_DONE;
                    n_count  = r_count + 7'd1;
                end
            end
            KIND_DELETE: begin
                if (w_ok_pos) begin
                    n_status = ST_DONE;
                    n_count  = r_count - 7'd1;
                end
            end
            KIND_MODIFY: if (w_ok_pos) n_status = ST_DONE;
            KIND_GET: begin
                if (w_ok_pos) begin
                    n_status = ST_DONE;
                    n_out    = w_rec[w_idx];
                end
            end
            KIND_FIND: n_status = w_any_hit ? ST_DONE : ST_NO_KEY;
            default: n_status = ST_BAD_POS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.entries   = r_count;
    assign o_rsp.out_key0  = r_out.key0;
    assign o_rsp.out_key1  = r_out.key1;
    assign o_rsp.out_key2  = r_out.key2;
    assign o_rsp.out_name0 = r_out.name0;
    assign o_rsp.out_name1 = r_out.name1;
    assign o_rsp.out_name2 = r_out.name2;
    assign o_rsp.out_name3 = r_out.name3;
    assign o_rsp.out_cost  = r_out.cost;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_rsp.ready |=> $stable(r_count) && r_valid)
        else $error("count moved during stall");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_count)) else $error("count changed without transaction");
endmodule
`default_nettype wire

>>> tb/tb_chan_if.sv
// testbench copy note: channel interfaces come from the rtl; this file holds the item struct
`timescale 1ns / 1ps
package tb_rec_pkg;
    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  position;
        logic [63:0] k0;
        logic [63:0] k1;
        logic [31:0] k2;
        logic [63:0] n0;
        logic [63:0] n1;
        logic [63:0] n2;
        logic [47:0] n3;
        logic [31:0] cost;
    } t_op;
endpackage

>>> tb/list_checker.sv
// checker that predicts record list responses and compares them
`timescale 1ns / 1ps
module list_checker
    import prl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prl_req_if.sink   i_req,
    prl_rsp_if.sink   i_rsp,
    output int        o_errors,
    output int        o_waiting
);
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] entries;
        t_record    rec;
    } t_answer;

    t_record    shelf [CAPACITY];
    int         fill;
    t_answer    answers [$];

    assign o_waiting = answers.size();

    function automatic t_answer apply_op(input t_record r, input logic [2:0] kind,
                                         input int pos);
        t_answer a;
        a = '0;
        a.status = ST_BAD_POS;
        case (kind)
            KIND_INSERT: begin
                if (pos == 0 || pos > fill + 1) a.status = ST_BAD_POS;
                else if (fill >= CAPACITY) a.status = ST_FULL;
                else begin
                    for (int i = fill; i >= pos; i--) shelf[i] = shelf[i-1];
                    shelf[pos-1] = r;
                    fill++;
                    a.status = ST_DONE;
                end
            end
            KIND_DELETE: begin
                if (pos == 0 || pos > fill) a.status = ST_BAD_POS;
                else begin
                    for (int i = pos; i < fill; i++) shelf[i-1] = shelf[i];
                    fill--;
                    a.status = ST_DONE;
                end
            end
            KIND_MODIFY: begin
                if (pos == 0 || pos > fill) a.status = ST_BAD_POS;
                else begin
                    shelf[pos-1] = r;
                    a.status = ST_DONE;
                end
            end
            KIND_GET: begin
                if (pos == 0 || pos > fill) a.status = ST_BAD_POS;
                else begin
                    a.rec = shelf[pos-1];
                    a.status = ST_DONE;
                end
            end
            KIND_FIND: begin
                a.status = ST_NO_KEY;
                for (int i = 0; i < fill; i++)
                    if (shelf[i].key0 == r.key0 && shelf[i].key1 == r.key1 &&
                        shelf[i].key2 == r.key2) a.status = ST_DONE;
            end
            default: a.status = ST_BAD_POS;
        endcase
        a.entries = fill[6:0];
        return a;
    endfunction

    task automatic cmp(input string f, input logic [63:0] e, input logic [63:0] g);
        if (e !== g) begin
            $error("%s expected %h got %h", f, e, g);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_record r;
        t_answer a;
        if (!i_rst_n) begin
            fill = 0;
            o_errors = 0;
            answers.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers.size() == 0) begin
                    $error("response with no transaction outstanding");
                    o_errors++;
                end else begin
                    a = answers.pop_front();
                    cmp("status", a.status, i_rsp.status);
                    cmp("entries", a.entries, i_rsp.entries);
                    cmp("out_key0", a.rec.key0, i_rsp.out_key0);
                    cmp("out_key1", a.rec.key1, i_rsp.out_key1);
                    cmp("out_key2", a.rec.key2, i_rsp.out_key2);
                    cmp("out_name0", a.rec.name0, i_rsp.out_name0);
                    cmp("out_name1", a.rec.name1, i_rsp.out_name1);
                    cmp("out_name2", a.rec.name2, i_rsp.out_name2);
                    cmp("out_name3", a.rec.name3, i_rsp.out_name3);
                    cmp("out_cost", a.rec.cost, i_rsp.out_cost);
                end
            end
            if (i_req.valid && i_req.ready) begin
                r = '{i_req.key_word0, i_req.key_word1, i_req.key_word2,
                      i_req.name_word0, i_req.name_word1, i_req.name_word2,
                      i_req.name_word3, i_req.cost};
                answers.push_back(apply_op(r, i_req.kind, int'(i_req.position)));
            end
        end
    end
endmodule

>>> tb/tb.sv
// testbench top: stimulus, idling phases and verdict for the record list
`timescale 1ns / 1ps
module tb;
    import prl_pkg::*;
    import tb_rec_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   waiting;
    int   send_idle;
    int   recv_stall;
    bit   hold_off;
    bit   stim_done;
    int   sent;

    prl_req_if req ();
    prl_rsp_if rsp ();

    positional_record_list u_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp));
    list_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_rsp(rsp),
                        .o_errors(errors), .o_waiting(waiting));

    logic [63:0] keys [8];
    int          model_fill;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_op rand_op(input logic [2:0] kind, input logic [6:0] pos);
        t_op o;
        int  k;
        k = $urandom_range(0, 7);
        o.kind = kind;
        o.position = pos;
        o.k0 = keys[k];
        o.k1 = keys[k] ^ 64'h5a;
        o.k2 = keys[k][31:0];
        if ($urandom_range(0, 5) == 0) begin
            o.k0 = r64();
            o.k1 = r64();
            o.k2 = $urandom;
        end
        o.n0 = r64();
        o.n1 = r64();
        o.n2 = r64();
        o.n3 = 48'(r64());
        o.cost = $urandom;
        return o;
    endfunction

    task automatic send(input t_op o);
        req.valid <= 1'b1;
        req.kind <= o.kind;
        req.position <= o.position;
        req.key_word0 <= o.k0;
        req.key_word1 <= o.k1;
        req.key_word2 <= o.k2;
        req.name_word0 <= o.n0;
        req.name_word1 <= o.n1;
        req.name_word2 <= o.n2;
        req.name_word3 <= o.n3;
        req.cost <= o.cost;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
        sent++;
        // track count for stimulus shaping only
        case (o.kind)
            KIND_INSERT: if (o.position != 0 && o.position <= model_fill + 1 &&
                             model_fill < CAPACITY) model_fill++;
            KIND_DELETE: if (o.position != 0 && o.position <= model_fill) model_fill--;
            default: ;
        endcase
        if ($urandom_range(0, 99) < send_idle) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        rsp.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic rand_phase(input int n);
        logic [2:0] kind;
        logic [6:0] pos;
        repeat (n) begin
            if (model_fill < 20) begin
                if ($urandom_range(0, 2) == 0) kind = 3'($urandom_range(1, 7));
                else kind = KIND_INSERT;
            end else begin
                kind = 3'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 15) == 0) pos = 7'($urandom);
            else pos = 7'($urandom_range(0, model_fill + 1));
            send(rand_op(kind, pos));
        end
    endtask

    initial begin
        t_op o;
        sent = 0;
        model_fill = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        stim_done = 0;
        foreach (keys[i]) keys[i] = r64();
        keys[0] = '0;
        keys[1] = '1;
        req.valid = 0;
        req.kind = '0;
        req.position = '0;
        req.key_word0 = '0;
        req.key_word1 = '0;
        req.key_word2 = '0;
        req.name_word0 = '0;
        req.name_word1 = '0;
        req.name_word2 = '0;
        req.name_word3 = '0;
        req.cost = '0;
        rsp.ready = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty list edges, zero position, extremes, unused kinds
        send(rand_op(KIND_GET, 7'd1));
        send(rand_op(KIND_DELETE, 7'd1));
        send(rand_op(KIND_FIND, 7'd0));
        send(rand_op(KIND_INSERT, 7'd0));
        send(rand_op(KIND_INSERT, 7'd2));
        o = rand_op(KIND_INSERT, 7'd1);
        o.k0 = '1; o.k1 = '1; o.k2 = '1; o.n0 = '1; o.n1 = '1; o.n2 = '1; o.n3 = '1;
        o.cost = 32'h8000_0000;
        send(o);
        o.position = 7'd1; o.k0 = '0; o.k1 = '0; o.k2 = '0; o.n0 = '0; o.n1 = '0;
        o.n2 = '0; o.n3 = '0; o.cost = 32'h7fff_ffff;
        send(o);
        send(rand_op(KIND_GET, 7'd1));
        send(rand_op(KIND_GET, 7'd2));
        send(rand_op(KIND_GET, 7'd0));
        send(rand_op(KIND_MODIFY, 7'd2));
        send(rand_op(KIND_MODIFY, 7'd0));
        send(rand_op(KIND_MODIFY, 7'd3));
        send(rand_op(KIND_FIND, 7'd127));
        send(rand_op(3'd5, 7'd1));
        send(rand_op(3'd6, 7'd1));
        send(rand_op(3'd7, 7'd127));
        send(rand_op(KIND_DELETE, 7'd2));
        send(rand_op(KIND_DELETE, 7'd127));
        // fill to capacity, then hit the full case
        while (model_fill < CAPACITY)
            send(rand_op(KIND_INSERT, 7'($urandom_range(1, model_fill + 1))));
        send(rand_op(KIND_INSERT, 7'd65));
        send(rand_op(KIND_INSERT, 7'd1));
        send(rand_op(KIND_GET, 7'd64));
        send(rand_op(KIND_DELETE, 7'd64));

        rand_phase(110);
        send_idle = 60;
        rand_phase(110);
        send_idle = 0;
        recv_stall = 60;
        rand_phase(110);
        send_idle = 38;
        recv_stall = 38;
        rand_phase(110);
        send_idle = 0;
        recv_stall = 0;
        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (60) @(negedge i_clk);
                hold_off = 0;
            end
            rand_phase(30);
        join
        @(negedge i_clk);
        req.valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (waiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule
